/* rtl/taf_pkg.sv */
// Shared types, constants and helpers for the triangle adjacency finder.
`default_nettype none
package taf_pkg;

  localparam int MAX_TRIANGLES_DEF     = 64;
  localparam int VERTEX_INDEX_BITS_DEF = 16;
  localparam int TRI_W  = 6;
  localparam int CNT_W  = 7;
  localparam int NB_W   = 7;
  localparam int EDGE_W = 2;
  localparam logic [NB_W-1:0] NB_NONE = NB_W'(64);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              vld;
    logic [TRI_W-1:0]  tidx;
    logic [EDGE_W-1:0] edg;
    logic              fnd;
    logic [EDGE_W-1:0] be2;
    logic [TRI_W-1:0]  bu;
  } qry_t;

  typedef struct packed {
    logic              en;
    logic [TRI_W-1:0]  tidx;
    logic [EDGE_W-1:0] edg;
    logic [TRI_W-1:0]  uidx;
    logic [EDGE_W-1:0] ue2;
  } wr_t;

  typedef logic [2:0][NB_W-1:0] nb_t;

  function automatic logic [EDGE_W-1:0] next_edge(input logic [EDGE_W-1:0] e);
    logic [EDGE_W-1:0] r;
    case (e)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/triangle_adjacency_finder.sv */
// Top level: triangle batch loader, edge query sequencer and cell chain.
// Each triangle is taken while start is high and busy is low. The triangle that
// carries last_triangle starts the search: one edge query enters the cell
// chain per cycle (3*n queries for n stored triangles), and each query walks
// the MAX_TRIANGLES cells, one cell per cycle, and writes any match back
// into the cells. The n results then leave on consecutive
// cycles, each marked by done_o for one cycle; the receiver cannot stall and
// must take each result as it appears. busy stays high from the final
// triangle until the last result is placed on the ports; it is low in the
// cycle that shows the last result.
`default_nettype none
module triangle_adjacency_finder
  import taf_pkg::*;
#(
  parameter int MAX_TRIANGLES     = MAX_TRIANGLES_DEF,
  parameter int VERTEX_INDEX_BITS = VERTEX_INDEX_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] vert_a_i,
  input  wire logic [15:0] vert_b_i,
  input  wire logic [15:0] vert_c_i,
  input  wire logic        last_triangle_i,
  output logic             done_o,
  output logic [5:0]       triangle_index_o,
  output logic [6:0]       neighbour_0_o,
  output logic [6:0]       neighbour_1_o,
  output logic [6:0]       neighbour_2_o,
  output logic             overflow_o,
  output logic             last_result_o
);

  localparam int VB = VERTEX_INDEX_BITS;
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_TRIANGLES);
  localparam logic [CNT_W-1:0] DRAIN_END = CNT_W'(MAX_TRIANGLES + 1);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic              ovf_q, ovf_d;
  logic [TRI_W-1:0]  qt_q, qt_d;
  logic [EDGE_W-1:0] qe_q, qe_d;
  logic [CNT_W-1:0]  dr_q, dr_d;
  logic [TRI_W-1:0]  oc_q, oc_d;
  qry_t              sq_q, sq_d;
  logic              accept, load, clr, shift, last_out;
  logic [2:0][VB-1:0] vert_in;
  wr_t               wr;

  qry_t          qc [MAX_TRIANGLES+1];
  logic [VB-1:0] pc [MAX_TRIANGLES+1];
  logic [VB-1:0] vc [MAX_TRIANGLES+1];
  nb_t           nbc [MAX_TRIANGLES+1];

  assign accept   = start && !busy;
  assign load     = accept && (n_q < MAX_CNT);
  assign vert_in  = {VB'(vert_c_i), VB'(vert_b_i), VB'(vert_a_i)};
  assign last_out = ({1'b0, oc_q} + CNT_W'(1)) == n_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && last_triangle_i) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (({1'b0, qt_q} + CNT_W'(1) == n_q) && (qe_q == 2'd2)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dr_q == DRAIN_END) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (last_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state_q != ST_IDLE);
    clr   = 1'b0;
    shift = 1'b0;
    n_d   = n_q;
    ovf_d = ovf_q;
    qt_d  = qt_q;
    qe_d  = qe_q;
    dr_d  = dr_q;
    oc_d  = oc_q;
    sq_d  = '0;
    unique case (state_q)
      ST_IDLE: begin
        qt_d = '0;
        qe_d = '0;
        dr_d = '0;
        oc_d = '0;
        if (accept) begin
          if (load) begin
            n_d = n_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          clr = last_triangle_i;
        end
      end
      ST_SEARCH: begin
        sq_d.vld  = 1'b1;
        sq_d.tidx = qt_q;
        sq_d.edg  = qe_q;
        if (qe_q == 2'd2) begin
          qe_d = '0;
          qt_d = qt_q + TRI_W'(1);
        end else begin
          qe_d = qe_q + EDGE_W'(1);
        end
      end
      ST_DRAIN: begin
        dr_d = dr_q + CNT_W'(1);
      end
      ST_OUT: begin
        shift = 1'b1;
        oc_d  = oc_q + TRI_W'(1);
        if (last_out) begin
          n_d   = '0;
          ovf_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      ovf_q   <= 1'b0;
      qt_q    <= '0;
      qe_q    <= '0;
      dr_q    <= '0;
      oc_q    <= '0;
      sq_q    <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      ovf_q   <= ovf_d;
      qt_q    <= qt_d;
      qe_q    <= qe_d;
      dr_q    <= dr_d;
      oc_q    <= oc_d;
      sq_q    <= sq_d;
      done_o  <= shift;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      triangle_index_o <= oc_q;
      neighbour_0_o    <= nbc[0][0];
      neighbour_1_o    <= nbc[0][1];
      neighbour_2_o    <= nbc[0][2];
      overflow_o       <= ovf_q;
      last_result_o    <= last_out;
    end
  end

  assign qc[0]  = sq_q;
  assign pc[0]  = '0;
  assign vc[0]  = '0;
  assign nbc[MAX_TRIANGLES] = {3{NB_NONE}};

  assign wr.en   = qc[MAX_TRIANGLES].vld && qc[MAX_TRIANGLES].fnd;
  assign wr.tidx = qc[MAX_TRIANGLES].tidx;
  assign wr.edg  = qc[MAX_TRIANGLES].edg;
  assign wr.uidx = qc[MAX_TRIANGLES].bu;
  assign wr.ue2  = qc[MAX_TRIANGLES].be2;

  for (genvar i = 0; i < MAX_TRIANGLES; i++) begin : g_cell
    taf_cell #(
      .VB(VB)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (TRI_W'(i)),
      .count_i  (n_q),
      .load_i   (load),
      .vert_i   (vert_in),
      .clr_i    (clr),
      .shift_i  (shift),
      .nb_next_i(nbc[i+1]),
      .nb_o     (nbc[i]),
      .wr_i     (wr),
      .q_i      (qc[i]),
      .pv_i     (pc[i]),
      .qv_i     (vc[i]),
      .q_o      (qc[i+1]),
      .pv_o     (pc[i+1]),
      .qv_o     (vc[i+1])
    );
  end

endmodule
`default_nettype wire

/* rtl/taf_cell.sv */
// One chain cell: stores a triangle and its neighbours, matches passing edge queries.
`default_nettype none
module taf_cell
  import taf_pkg::*;
#(
  parameter int VB = VERTEX_INDEX_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [TRI_W-1:0] idx_i,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire logic             load_i,
  input  wire logic [2:0][VB-1:0] vert_i,
  input  wire logic             clr_i,
  input  wire logic             shift_i,
  input  wire nb_t              nb_next_i,
  output nb_t                   nb_o,
  input  wire wr_t              wr_i,
  input  wire qry_t             q_i,
  input  wire logic [VB-1:0]    pv_i,
  input  wire logic [VB-1:0]    qv_i,
  output qry_t                  q_o,
  output logic [VB-1:0]         pv_o,
  output logic [VB-1:0]         qv_o
);

  logic [2:0][VB-1:0] vert_q;
  nb_t                nb_q;
  qry_t               q_q, q_d;
  logic [VB-1:0]      pv_q, pv_d, qv_q, qv_d;
  logic [2:0]         hit;
  logic [EDGE_W-1:0]  fe;
  logic               active;

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      hit[e] = (vert_q[e] == qv_i) && (vert_q[next_edge(EDGE_W'(e))] == pv_i);
    end
    if (hit[0]) begin
      fe = 2'd0;
    end else if (hit[1]) begin
      fe = 2'd1;
    end else begin
      fe = 2'd2;
    end
    active = q_i.vld && (idx_i > q_i.tidx) && ({1'b0, idx_i} < count_i);
    q_d  = q_i;
    pv_d = pv_i;
    qv_d = qv_i;
    if (q_i.vld && (idx_i == q_i.tidx)) begin
      pv_d = vert_q[q_i.edg];
      qv_d = vert_q[next_edge(q_i.edg)];
    end
    if (active && (|hit) && (!q_i.fnd || (fe < q_i.be2))) begin
      q_d.fnd = 1'b1;
      q_d.be2 = fe;
      q_d.bu  = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else begin
      q_q <= q_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pv_q     <= pv_d;
    qv_q     <= qv_d;
    if (load_i && ({1'b0, idx_i} == count_i)) begin
      vert_q <= vert_i;
    end
    if (clr_i) begin
      nb_q <= {3{NB_NONE}};
    end else if (shift_i) begin
      nb_q <= nb_next_i;
    end else begin
      if (wr_i.en && (wr_i.tidx == idx_i)) begin
        nb_q[wr_i.edg] <= {1'b0, wr_i.uidx};
      end
      if (wr_i.en && (wr_i.uidx == idx_i)) begin
        nb_q[wr_i.ue2] <= {1'b0, wr_i.tidx};
      end
    end
  end

  assign q_o  = q_q;
  assign pv_o = pv_q;
  assign qv_o = qv_q;
  assign nb_o = nb_q;

endmodule
`default_nettype wire
